FILE: rtl/lch_pkg.sv
package lch_pkg;

  // Fixed field widths
  localparam int COORD_BITS       = 12;
  localparam int CHANNEL_BITS_DEF = 16;
  localparam int MAX_LEVELS_DEF   = 5;
  localparam int OFFSET_COUNT     = 5;

  // Top-down row: height (13 bit) minus one minus row, signed
  localparam int HEIGHT_W = 13;
  localparam int Y_W      = ((COORD_BITS > HEIGHT_W) ? COORD_BITS : HEIGHT_W) + 2;

  // Sine and cosine in Q16, signed
  localparam int CS_W = 19;
  // Projection in Q16 and its integer part
  localparam int RC_W = CS_W + Y_W + 1;
  localparam int IP_W = RC_W - 16;

  // CORDIC datapath
  localparam int CORDIC_W     = 33;
  localparam int ANG_W        = 21;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 5;

  localparam logic signed [ANG_W-1:0] PI_Q16      = 21'sd205887;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q16  = 21'sd411775;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 21'sd102944;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;

  localparam logic signed [ANG_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
    21'sd51472, 21'sd30386, 21'sd16055, 21'sd8150, 21'sd4091, 21'sd2047,
    21'sd1024, 21'sd512, 21'sd256, 21'sd128, 21'sd64, 21'sd32, 21'sd16,
    21'sd8, 21'sd4, 21'sd2
  };

  // Stroke direction offsets per hatch set, Q3.13 radians
  localparam logic signed [15:0] ANG_OFF [OFFSET_COUNT] = '{
    16'sd0, 16'sd12868, 16'sd6434, -16'sd6434, 16'sd9651
  };

  // Reciprocal of the stroke spacing, ceil(2^RECIP_SHIFT / spacing)
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // Luma weights, Q16
  localparam int LUMA_R = 13933;
  localparam int LUMA_G = 46871;
  localparam int LUMA_B = 4732;

  // Pen width per pixel of spacing, Q16 (0.14)
  localparam int BAND_PER_PX = 9175;
  localparam int BAND_W      = 21;
  localparam int ONE_Q16     = 65536;
  localparam int HALF_Q16    = 32768;

  typedef enum logic [2:0] {
    CFG_SPACING = 3'd0,
    CFG_LEVELS  = 3'd1,
    CFG_ANGLE   = 3'd2,
    CFG_GAIN    = 3'd3,
    CFG_MIX     = 3'd4,
    CFG_INK     = 3'd5,
    CFG_PAPER   = 3'd6,
    CFG_HEIGHT  = 3'd7
  } lch_cfg_e;

  typedef enum logic [2:0] {
    SU_START,
    SU_DIV,
    SU_LOAD,
    SU_ROT,
    SU_STORE,
    SU_IDLE
  } lch_su_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] col_pos;
    logic [COORD_BITS-1:0] row_pos;
    logic [15:0]           in_red;
    logic [15:0]           in_green;
    logic [15:0]           in_blue;
    logic [15:0]           in_alpha;
  } lch_in_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic        ink_hit;
  } lch_out_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } lch_pix_t;

endpackage

FILE: rtl/luma_crosshatch_shader_unit.sv
// Luma driven crosshatch shader, one RGBA pixel in, one shaded pixel out.
//
// Input channel: in_valid_i / in_stall_o / in_data_i carry a pixel request
// (column, row from the bottom, red, green, blue, alpha). Output channel:
// out_valid_o / out_stall_i / out_data_o carry the mixed colour, the alpha
// and the ink flag. A request moves at an edge with valid high, stall low.
// Throughput: one pixel per clock while no setup pass runs and the output
// is not stalled; a pixel passes through nine register stages.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i at
// the edge. Each write, and reset, starts a setup pass that computes the
// spacing reciprocal (23 division steps) and the stroke sine and cosine
// per hatch set (one CORDIC unit, one set after another); in_stall_o
// stays high during the pass. Write registers only with the pipe empty.
// Reset: asynchronous, active low; registers return to their defaults and
// the pipeline empties. When the receiver stalls a waiting result, the whole
// pipeline holds and in_stall_o rises in the same cycle; nothing is lost.
module luma_crosshatch_shader_unit #(
  parameter int CHANNEL_BITS = lch_pkg::CHANNEL_BITS_DEF,
  parameter int MAX_LEVELS   = lch_pkg::MAX_LEVELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lch_pkg::lch_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lch_pkg::lch_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [47:0]      cfg_data_i
);
  import lch_pkg::*;

  localparam int CB      = CHANNEL_BITS;
  localparam int CMAX    = (1 << CB) - 1;
  localparam int LSUM_W  = CB + 17;
  localparam int COLP_W  = CB + 16;
  localparam int QP_W    = IP_W + RECIP_W + 1;
  localparam int MP_W    = CB + 19;
  localparam int V_W     = CB + 5;
  localparam int NSTAGE  = 9;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [6:0]  sp_q;
  logic [2:0]  lev_q;
  logic [15:0] ang_q;
  logic [13:0] gain_q;
  logic [16:0] mix_q;
  logic [47:0] ink_q, paper_q;
  logic [12:0] height_q;
  logic [2:0]  lev_wr;

  always_comb begin
    lev_wr = cfg_data_i[2:0];
    if (lev_wr < 3'd2) lev_wr = 3'd2;
    else if (lev_wr > 3'(MAX_LEVELS)) lev_wr = 3'(MAX_LEVELS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= 7'd8;
      lev_q    <= 3'd4;
      ang_q    <= 16'd5734;
      gain_q   <= 14'd4506;
      mix_q    <= 17'd65536;
      ink_q    <= 48'd28149559267164;
      paper_q  <= 48'd270217609731112;
      height_q <= 13'd1080;
    end else if (cfg_we_i) begin
      case (lch_cfg_e'(cfg_index_i))
        CFG_SPACING: sp_q     <= cfg_data_i[6:0];
        CFG_LEVELS:  lev_q    <= lev_wr;
        CFG_ANGLE:   ang_q    <= cfg_data_i[15:0];
        CFG_GAIN:    gain_q   <= cfg_data_i[13:0];
        CFG_MIX:     mix_q    <= cfg_data_i[16:0];
        CFG_INK:     ink_q    <= cfg_data_i;
        CFG_PAPER:   paper_q  <= cfg_data_i;
        CFG_HEIGHT:  height_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Values derived from the registers, settled during the setup pass
  logic [6:0]         sp_eff;
  logic [BAND_W-1:0]  band_q;
  logic [COLP_W-1:0]  inkp_q [3];
  logic [COLP_W-1:0]  papp_q [3];
  logic [CB-1:0]      inko_q [3];
  logic [CB-1:0]      papo_q [3];

  assign sp_eff = (sp_q == 7'd0) ? 7'd1 : sp_q;

  // Rescale a 16-bit colour field to the channel range, rounded
  function automatic logic [CB-1:0] rescale(input logic [COLP_W-1:0] t);
    logic [COLP_W-1:0] q, r;
    q = '0;
    r = t;
    for (int f = 0; f < 3; f++) begin
      q = q + (r >> 16);
      r = COLP_W'(r[15:0]) + (r >> 16);
    end
    if (r >= COLP_W'(65535)) q = q + COLP_W'(1);
    return CB'(q);
  endfunction

  always_ff @(posedge clk_i) begin
    logic [BAND_W-1:0] bw;
    bw = BAND_W'(sp_eff) * BAND_W'(BAND_PER_PX);
    band_q <= (bw < BAND_W'(ONE_Q16)) ? BAND_W'(ONE_Q16) : bw;
    for (int j = 0; j < 3; j++) begin
      inkp_q[j] <= COLP_W'(ink_q[32-16*j +: 16]) * COLP_W'(CMAX) + COLP_W'(32767);
      papp_q[j] <= COLP_W'(paper_q[32-16*j +: 16]) * COLP_W'(CMAX) + COLP_W'(32767);
      inko_q[j] <= rescale(inkp_q[j]);
      papo_q[j] <= rescale(papp_q[j]);
    end
  end

  // ---------------------------------------------------------------------
  // Setup unit
  logic                    busy;
  logic [RECIP_W-1:0]      recip;
  logic signed [CS_W-1:0]  cs_v [MAX_LEVELS];
  logic signed [CS_W-1:0]  sn_v [MAX_LEVELS];

  lch_setup #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_setup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cfg_we_i),
    .sp_i   (sp_eff),
    .angle_i($signed(ang_q)),
    .busy_o (busy),
    .recip_o(recip),
    .cos_o  (cs_v),
    .sin_o  (sn_v)
  );

  // ---------------------------------------------------------------------
  // Pipeline control: all stages advance together unless the output holds
  logic [NSTAGE:1] v_q;
  logic            adv;

  assign adv        = !v_q[NSTAGE] || !out_stall_i;
  assign in_stall_o = busy || !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTAGE-1:1], in_valid_i && !in_stall_o};
    end
  end

  // Pipeline registers
  lch_pix_t                pix_q [1:8];
  logic [COORD_BITS-1:0]   x1_q;
  logic signed [Y_W-1:0]   y1_q;
  logic [LSUM_W-1:0]       lsum2_q;
  logic signed [RC_W-1:0]  px2_q [MAX_LEVELS];
  logic signed [RC_W-1:0]  py2_q [MAX_LEVELS];
  logic [16:0]             lum3_q;
  logic signed [RC_W-1:0]  rc3_q [MAX_LEVELS];
  logic signed [32:0]      cp4_q;
  logic signed [RC_W-1:0]  rc4_q [MAX_LEVELS];
  logic [16:0]             dk5_q;
  logic signed [IP_W-1:0]  ip5_q [MAX_LEVELS];
  logic signed [IP_W-1:0]  qe5_q [MAX_LEVELS];
  logic [15:0]             fr5_q [MAX_LEVELS];
  logic [7:0]              rem6_q [MAX_LEVELS];
  logic [15:0]             fr6_q [MAX_LEVELS];
  logic [MAX_LEVELS-1:0]   act6_q;
  logic                    hit7_q;
  logic signed [MP_W-1:0]  mp8_q [3];
  logic                    hit8_q;
  lch_out_t                out_q;

  // Stage combinational results
  logic [LSUM_W-1:0]       lum_s, lum_r, lum_div;
  logic signed [17:0]      cen;
  logic signed [20:0]      dk_t;
  logic signed [21:0]      dk_u;
  logic [16:0]             dk;
  logic [19:0]             dk_lev;
  logic                    hit;
  logic [CB-1:0]           chan7 [3];
  logic [CB-1:0]           chan8 [3];
  logic [CB-1:0]           col_o [3];
  logic [CB-1:0]           mix_res [3];

  // Luma divide by the channel full scale: fold by 2^CB - 1, then correct once
  always_comb begin
    lum_s   = lsum2_q + LSUM_W'(CMAX / 2);
    lum_div = '0;
    lum_r   = lum_s;
    for (int f = 0; f < 4; f++) begin
      lum_div = lum_div + (lum_r >> CB);
      lum_r   = LSUM_W'(lum_r[CB-1:0]) + (lum_r >> CB);
    end
    if (lum_r >= LSUM_W'(CMAX)) lum_div = lum_div + LSUM_W'(1);
  end

  // Darkness, stretched about one half and clamped
  always_comb begin
    cen  = 18'sd32768 - $signed({1'b0, lum3_q});
    dk_t = 21'((cp4_q + 33'sd2048) >>> 12);
    dk_u = 22'(dk_t) + 22'sd32768;
    if (dk_u < 22'sd0) dk = '0;
    else if (dk_u > 22'sd65536) dk = 17'd65536;
    else dk = 17'(dk_u);
    dk_lev = 20'(dk5_q) * 20'(lev_q);
  end

  // Stroke hit over the active hatch sets
  always_comb begin
    logic [6:0]  rr;
    logic [22:0] pos;
    hit = 1'b0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      rr  = (rem6_q[k] >= {1'b0, sp_eff}) ? 7'(rem6_q[k] - {1'b0, sp_eff}) : rem6_q[k][6:0];
      pos = {rr, fr6_q[k]};
      if (act6_q[k] && (3'(k) < lev_q) && (pos < 23'(band_q))) hit = 1'b1;
    end
  end

  // Colour mix
  always_comb begin
    logic signed [MP_W:0]  rnd;
    logic signed [V_W-1:0] v;
    chan7[0] = pix_q[7].red[CB-1:0];
    chan7[1] = pix_q[7].green[CB-1:0];
    chan7[2] = pix_q[7].blue[CB-1:0];
    chan8[0] = pix_q[8].red[CB-1:0];
    chan8[1] = pix_q[8].green[CB-1:0];
    chan8[2] = pix_q[8].blue[CB-1:0];
    for (int j = 0; j < 3; j++) begin
      col_o[j] = hit7_q ? inko_q[j] : papo_q[j];
      rnd = (MP_W+1)'(mp8_q[j]) + (MP_W+1)'(32768);
      v   = V_W'($signed({1'b0, chan8[j]})) + V_W'(rnd >>> 16);
      if (v < V_W'(0)) mix_res[j] = '0;
      else if (v > V_W'(CMAX)) mix_res[j] = CB'(CMAX);
      else mix_res[j] = CB'(v);
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [QP_W-1:0]   qprod;
    logic signed [IP_W+8:0]   remw;
    logic signed [CB:0]       diff;
    if (adv) begin
      // Stage 1: capture, mask and flip the row
      pix_q[1].red   <= 16'(in_data_i.in_red[CB-1:0]);
      pix_q[1].green <= 16'(in_data_i.in_green[CB-1:0]);
      pix_q[1].blue  <= 16'(in_data_i.in_blue[CB-1:0]);
      pix_q[1].alpha <= 16'(in_data_i.in_alpha[CB-1:0]);
      x1_q <= in_data_i.col_pos;
      y1_q <= $signed(Y_W'(height_q)) - Y_W'(1) - $signed(Y_W'(in_data_i.row_pos));
      for (int s = 2; s <= 8; s++) pix_q[s] <= pix_q[s-1];

      // Stage 2: luma products and projection products
      lsum2_q <= LSUM_W'(LUMA_R) * LSUM_W'(pix_q[1].red[CB-1:0])
               + LSUM_W'(LUMA_G) * LSUM_W'(pix_q[1].green[CB-1:0])
               + LSUM_W'(LUMA_B) * LSUM_W'(pix_q[1].blue[CB-1:0]);
      for (int k = 0; k < MAX_LEVELS; k++) begin
        px2_q[k] <= cs_v[k] * $signed({1'b0, x1_q});
        py2_q[k] <= sn_v[k] * y1_q;
      end

      // Stage 3: luma and projection
      lum3_q <= 17'(lum_div);
      for (int k = 0; k < MAX_LEVELS; k++) rc3_q[k] <= px2_q[k] + py2_q[k];

      // Stage 4: contrast product
      cp4_q <= cen * $signed({1'b0, gain_q});
      rc4_q <= rc3_q;

      // Stage 5: darkness, quotient estimate by the spacing reciprocal
      dk5_q <= dk;
      for (int k = 0; k < MAX_LEVELS; k++) begin
        ip5_q[k] <= $signed(rc4_q[k][RC_W-1:16]);
        fr5_q[k] <= rc4_q[k][15:0];
        qprod    = $signed(rc4_q[k][RC_W-1:16]) * $signed({1'b0, recip});
        qe5_q[k] <= IP_W'(qprod >>> RECIP_SHIFT);
      end

      // Stage 6: remainder below twice the spacing, level tests
      for (int k = 0; k < MAX_LEVELS; k++) begin
        remw = (IP_W+9)'(ip5_q[k]) - qe5_q[k] * $signed({1'b0, sp_eff});
        rem6_q[k] <= 8'(remw);
        fr6_q[k]  <= fr5_q[k];
        act6_q[k] <= dk_lev > (20'(k) << 16);
      end

      // Stage 7: ink test
      hit7_q <= hit;

      // Stage 8: blend products
      for (int j = 0; j < 3; j++) begin
        diff = $signed({1'b0, col_o[j]}) - $signed({1'b0, chan7[j]});
        mp8_q[j] <= diff * $signed({1'b0, mix_q});
      end
      hit8_q <= hit7_q;

      // Stage 9: output register
      out_q.out_red   <= 16'(mix_res[0]);
      out_q.out_green <= 16'(mix_res[1]);
      out_q.out_blue  <= 16'(mix_res[2]);
      out_q.out_alpha <= pix_q[8].alpha;
      out_q.ink_hit   <= hit8_q;
    end
  end

  assign out_valid_o = v_q[NSTAGE];
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // A register write always restarts the setup pass
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy) else $error("setup not restarted after write");

  // No pixel enters while the setup tables are stale
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !busy) else $error("pixel taken during setup");

  // The pipe holds its valid bits while the output is stalled
  a_pipe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NSTAGE] && out_stall_i) |=> $stable(v_q)) else $error("pipe moved under stall");

  // Reciprocal is the rounded-up inverse of the spacing once setup is done
  a_recip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> ((31'(recip) * 31'(sp_eff)) >= 31'(1 << RECIP_SHIFT)) &&
              ((31'(recip) * 31'(sp_eff)) < 31'(1 << RECIP_SHIFT) + 31'(sp_eff)))
    else $error("spacing reciprocal wrong");
`endif

endmodule

FILE: rtl/lch_setup.sv
module lch_setup #(
  parameter int MAX_LEVELS = lch_pkg::MAX_LEVELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [6:0]                         sp_i,
  input  logic signed [15:0]                 angle_i,
  output logic                               busy_o,
  output logic [lch_pkg::RECIP_W-1:0]        recip_o,
  output logic signed [lch_pkg::CS_W-1:0]    cos_o [MAX_LEVELS],
  output logic signed [lch_pkg::CS_W-1:0]    sin_o [MAX_LEVELS]
);
  import lch_pkg::*;

  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  lch_su_e                    state_q, state_d;
  logic [STEP_W-1:0]          cnt_q, cnt_d;
  logic [LVL_W-1:0]           lvl_q, lvl_d;
  logic [RECIP_W-1:0]         num_q, num_d;
  logic [6:0]                 rem_q, rem_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [ANG_W-1:0]    a_q, a_d;
  logic                       neg_q, neg_d;
  logic                       cs_we;
  logic signed [CS_W-1:0]     cos_q [MAX_LEVELS];
  logic signed [CS_W-1:0]     sin_q [MAX_LEVELS];
  logic signed [CS_W-1:0]     cos_d, sin_d;

  // Sequence: reciprocal by restoring division, then one CORDIC pass per hatch set
  always_comb begin
    logic [7:0]                 trial;
    logic signed [16:0]         asum;
    logic signed [ANG_W-1:0]    ang;
    logic                       flip;
    logic [3:0]                 step;
    logic signed [CORDIC_W-1:0] xs, ys, xf, yf, xr, yr;
    state_d = state_q;
    cnt_d   = cnt_q;
    lvl_d   = lvl_q;
    num_d   = num_q;
    rem_d   = rem_q;
    x_d     = x_q;
    y_d     = y_q;
    a_d     = a_q;
    neg_d   = neg_q;
    cs_we   = 1'b0;
    trial   = '0;
    asum    = '0;
    ang     = '0;
    flip    = 1'b0;
    step    = cnt_q[3:0];
    xs      = x_q >>> step;
    ys      = y_q >>> step;
    xf      = neg_q ? -x_q : x_q;
    yf      = neg_q ? -y_q : y_q;
    xr      = xf + CORDIC_W'(8192);
    yr      = yf + CORDIC_W'(8192);
    cos_d   = CS_W'(xr >>> 14);
    sin_d   = CS_W'(yr >>> 14);
    case (state_q)
      SU_START: begin
        num_d   = RECIP_W'(1 << RECIP_SHIFT) + RECIP_W'(sp_i) - RECIP_W'(1);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = SU_DIV;
      end
      SU_DIV: begin
        trial = {rem_q, num_q[RECIP_W-1]};
        if (trial >= {1'b0, sp_i}) begin
          rem_d = 7'(trial - {1'b0, sp_i});
          num_d = {num_q[RECIP_W-2:0], 1'b1};
        end else begin
          rem_d = trial[6:0];
          num_d = {num_q[RECIP_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == STEP_W'(RECIP_W - 1)) begin
          cnt_d   = '0;
          lvl_d   = '0;
          state_d = SU_LOAD;
        end
      end
      SU_LOAD: begin
        // Angle in Q16, folded into half a turn either side of zero, then into a quarter turn with a flip
        asum = 17'(angle_i) + 17'(ANG_OFF[lvl_q]);
        ang  = ANG_W'(asum) <<< 3;
        if (ang > PI_Q16) ang = ang - TWO_PI_Q16;
        if (ang < -PI_Q16) ang = ang + TWO_PI_Q16;
        if (ang > HALF_PI_Q16) begin
          ang  = ang - PI_Q16;
          flip = 1'b1;
        end else if (ang < -HALF_PI_Q16) begin
          ang  = ang + PI_Q16;
          flip = 1'b1;
        end
        a_d     = ang;
        neg_d   = flip;
        x_d     = CORDIC_X0;
        y_d     = '0;
        cnt_d   = '0;
        state_d = SU_ROT;
      end
      SU_ROT: begin
        if (!a_q[ANG_W-1]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          a_d = a_q - ATAN_Q16[step];
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          a_d = a_q + ATAN_Q16[step];
        end
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
          state_d = SU_STORE;
        end
      end
      SU_STORE: begin
        cs_we = 1'b1;
        if (lvl_q == LVL_W'(MAX_LEVELS - 1)) begin
          state_d = SU_IDLE;
        end else begin
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = SU_LOAD;
        end
      end
      SU_IDLE: begin
        state_d = SU_IDLE;
      end
      default: begin
        state_d = SU_START;
      end
    endcase
    // Restart on any register write
    if (start_i) state_d = SU_START;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SU_START;
      cnt_q   <= '0;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lvl_q   <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    x_q   <= x_d;
    y_q   <= y_d;
    a_q   <= a_d;
    neg_q <= neg_d;
    if (cs_we) begin
      cos_q[lvl_q] <= cos_d;
      sin_q[lvl_q] <= sin_d;
    end
  end

  assign busy_o  = (state_q != SU_IDLE);
  assign recip_o = num_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

FILE: test/lch_checker.sv
module lch_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  lch_pkg::lch_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  lch_pkg::lch_out_t out_data_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [47:0]       cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lch_pkg::*;

  localparam longint CHAN_MAX = 65535;
  localparam longint TURN_Q16 = 411775;
  localparam longint HALF_TURN_Q16 = 205887;
  localparam longint QUARTER_TURN_Q16 = 102944;

  // Shadow copy of the configuration registers
  logic [6:0]  spacing_q;
  logic [2:0]  levels_q;
  logic [15:0] angle_q;
  logic [13:0] gain_q;
  logic [16:0] mix_q;
  logic [47:0] ink_q;
  logic [47:0] paper_q;
  logic [12:0] height_q;

  lch_out_t shaded_q[$];

  // Floored arithmetic shift right
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void stroke_sincos(longint a, output longint c, output longint s);
    longint x, y, t;
    bit     flip;
    int     atan_tab[16];
    x = 652032874;
    y = 0;
    flip = 0;
    atan_tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128, 64,
                 32, 16, 8, 4, 2};
    if (a > HALF_TURN_Q16) a -= TURN_Q16;
    if (a < -HALF_TURN_Q16) a += TURN_Q16;
    if (a > QUARTER_TURN_Q16) begin
      a -= HALF_TURN_Q16;
      flip = 1;
    end else if (a < -QUARTER_TURN_Q16) begin
      a += HALF_TURN_Q16;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (a >= 0) begin
        t = x - floor_shr(y, i); y = y + floor_shr(x, i); x = t; a -= atan_tab[i];
      end else begin
        t = x + floor_shr(y, i); y = y - floor_shr(x, i); x = t; a += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = floor_shr(x + 8192, 14);
    s = floor_shr(y + 8192, 14);
  endfunction

  function automatic lch_out_t shade_pixel(lch_in_t px);
    lch_out_t res;
    longint   chan[3], col, row, sp, pitch, band, lum, cen, dark, nlev;
    longint   cs, sn, proj, rem, ang, base, tone, mixed;
    longint   offs[5];
    logic [47:0] pick;
    bit       hit;
    offs = '{0, 12868, 6434, -6434, 9651};
    chan[0] = px.in_red;
    chan[1] = px.in_green;
    chan[2] = px.in_blue;
    col = px.col_pos;
    row = longint'(height_q) - 1 - longint'(px.row_pos);
    lum = (13933 * chan[0] + 46871 * chan[1] + 4732 * chan[2] + CHAN_MAX / 2) / CHAN_MAX;
    cen = 32768 - lum;
    dark = floor_shr(cen * longint'(gain_q) + 2048, 12) + 32768;
    if (dark < 0) dark = 0;
    if (dark > 65536) dark = 65536;
    sp = (spacing_q == 0) ? 1 : longint'(spacing_q);
    pitch = sp * 65536;
    band = sp * 9175;
    if (band < 65536) band = 65536;
    nlev = levels_q;
    hit = 0;
    base = longint'($signed(angle_q));
    for (int k = 0; k < nlev; k++) begin
      if (dark * nlev > k * 65536) begin
        ang = (base + offs[k]) * 8;
        stroke_sincos(ang, cs, sn);
        proj = cs * col + sn * row;
        rem = proj % pitch;
        if (rem < 0) rem += pitch;
        if (rem < band) begin
          hit = 1;
          break;
        end
      end
    end
    pick = hit ? ink_q : paper_q;
    for (int j = 0; j < 3; j++) begin
      tone = pick[32-16*j +: 16];
      tone = (tone * CHAN_MAX + 32767) / 65535;
      mixed = chan[j] + floor_shr((tone - chan[j]) * longint'(mix_q) + 32768, 16);
      if (mixed < 0) mixed = 0;
      if (mixed > CHAN_MAX) mixed = CHAN_MAX;
      if (j == 0) res.out_red = mixed[15:0];
      else if (j == 1) res.out_green = mixed[15:0];
      else res.out_blue = mixed[15:0];
    end
    res.out_alpha = px.in_alpha;
    res.ink_hit = hit;
    return res;
  endfunction

  assign pending_o = shaded_q.size();

  // Track configuration, predict accepted requests, compare results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= 7'd8;
      levels_q <= 3'd4;
      angle_q <= 16'd5734;
      gain_q <= 14'd4506;
      mix_q <= 17'd65536;
      ink_q <= 48'd28149559267164;
      paper_q <= 48'd270217609731112;
      height_q <= 13'd1080;
      fail_count_o <= 0;
      shaded_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (lch_cfg_e'(cfg_index_i))
          CFG_SPACING: spacing_q <= cfg_data_i[6:0];
          CFG_LEVELS: begin
            if (cfg_data_i[2:0] < 3'd2) levels_q <= 3'd2;
            else if (cfg_data_i[2:0] > 3'd5) levels_q <= 3'd5;
            else levels_q <= cfg_data_i[2:0];
          end
          CFG_ANGLE: angle_q <= cfg_data_i[15:0];
          CFG_GAIN: gain_q <= cfg_data_i[13:0];
          CFG_MIX: mix_q <= cfg_data_i[16:0];
          CFG_INK: ink_q <= cfg_data_i;
          CFG_PAPER: paper_q <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (shaded_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          lch_out_t exp_px;
          exp_px = shaded_q.pop_front();
          if (exp_px !== out_data_i) begin
            $display("%0t: expected %h actual %h", $time, exp_px, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) shaded_q = {shaded_q, shade_pixel(in_data_i)};
    end
  end
endmodule

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lch_pkg::*;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, cfg_we_i;
  lch_in_t  in_data_i;
  lch_out_t out_data_o;
  logic [2:0]  cfg_index_i;
  logic [47:0] cfg_data_i;
  int fail_count, pending;
  int send_gap_pct, recv_stall_pct;
  int quiet_cycles;

  luma_crosshatch_shader_unit dut (.*);

  lch_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver stalls at random
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // Watchdog: cycles without any accepted request, delivered result or register write
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("luma_crosshatch_shader_unit: mismatch");
      $finish;
    end
  end

  // Hold the write enable high across back-to-back writes; the caller drops it
  task automatic write_reg(lch_cfg_e idx, logic [47:0] val);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // Drop the request, wait until every result is out, then settle
  task automatic drain();
    in_valid_i <= 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_pixel(lch_in_t px);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= px;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic lch_in_t rand_pixel();
    lch_in_t px;
    px = 88'({$urandom, $urandom, $urandom});
    case ($urandom_range(5))
      0: px.in_red = '0;
      1: px.in_green = 16'hffff;
      2: begin
        px.in_red = 16'hffff; px.in_green = 16'hffff; px.in_blue = 16'hffff;
      end
      3: px.in_green = 16'($urandom_range(16'h2000));
      default: ;
    endcase
    return px;
  endfunction

  task automatic rand_config(bit extreme);
    write_reg(CFG_SPACING, extreme ? ($urandom_range(1) ? 48'd0 : 48'd127)
                                   : 48'($urandom_range(1, 64)));
    write_reg(CFG_LEVELS, 48'($urandom_range(7)));
    write_reg(CFG_ANGLE, extreme ? ($urandom_range(1) ? 48'(-25736) & 48'hffff : 48'd25736)
                                 : 48'($urandom));
    write_reg(CFG_GAIN, extreme ? ($urandom_range(1) ? 48'd2048 : 48'h3fff)
                                : 48'($urandom_range(2048, 10240)));
    write_reg(CFG_MIX, extreme ? ($urandom_range(1) ? 48'd0 : 48'h1ffff)
                               : 48'($urandom_range(65536)));
    write_reg(CFG_INK, 48'({$urandom, $urandom}));
    write_reg(CFG_PAPER, 48'({$urandom, $urandom}));
    write_reg(CFG_HEIGHT, extreme ? ($urandom_range(1) ? 48'd0 : 48'h1fff)
                                  : 48'($urandom_range(1, 4096)));
    cfg_we_i <= 0;
  endtask

  initial begin
    rst_ni = 0;
    in_valid_i = 0;
    in_data_i = '0;
    out_stall_i = 0;
    cfg_we_i = 0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    quiet_cycles = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    repeat (130) @(posedge clk_i);

    // Directed: field extremes at reset settings
    send_pixel('0);
    send_pixel('1);
    send_pixel('{12'd0, 12'd4095, 16'hffff, 16'h0, 16'hffff, 16'h1234});
    send_pixel('{12'd4095, 12'd0, 16'h0, 16'hffff, 16'h0, 16'hffff});
    send_pixel('{12'd100, 12'd2000, 16'h8000, 16'h8000, 16'h8000, 16'h0});
    drain();
    // Directed: zero spacing, over-wide spacing, level clamps, heights of zero and one
    write_reg(CFG_SPACING, 48'd0);
    write_reg(CFG_LEVELS, 48'd0);
    write_reg(CFG_HEIGHT, 48'd0);
    write_reg(CFG_MIX, 48'h1ffff);
    cfg_we_i <= 0;
    repeat (130) @(posedge clk_i);
    for (int i = 0; i < 6; i++) send_pixel(rand_pixel());
    drain();
    write_reg(CFG_SPACING, 48'd127);
    write_reg(CFG_LEVELS, 48'd7);
    write_reg(CFG_HEIGHT, 48'd1);
    cfg_we_i <= 0;
    repeat (130) @(posedge clk_i);
    for (int i = 0; i < 6; i++) send_pixel(rand_pixel());
    drain();
    repeat (130) @(posedge clk_i);

    // Random phases with changing idle patterns and settings
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin
        send_gap_pct = 15; recv_stall_pct = 82;
      end else if (ph < 8) begin
        send_gap_pct = 82; recv_stall_pct = 15;
      end else begin
        send_gap_pct = 0; recv_stall_pct = 0;
      end
      rand_config(ph % 3 == 0);
      repeat (130) @(posedge clk_i);
      for (int i = 0; i < 50; i++) begin
        if (i == 25) begin
          in_valid_i <= 0;
          do @(posedge clk_i); while (pending != 0);
        end
        send_pixel(rand_pixel());
      end
      drain();
      repeat (130) @(posedge clk_i);
    end

    recv_stall_pct = 0;
    drain();
    if (fail_count == 0) $display("luma_crosshatch_shader_unit: match");
    else $display("luma_crosshatch_shader_unit: mismatch");
    $finish;
  end
endmodule
